// ----- design/sbdp_pkg.sv -----
// Shared types and constants for the single-bin DFT power block.
// No dependencies; every design file refers to it by scoped names.
package sbdp_pkg;

    localparam int TABLE_DEPTH_DEF   = 256;
    localparam int FRACTION_BITS_DEF = 14;

    localparam int SAMPLE_W   = 16;
    localparam int COEFF_W    = 16;
    localparam int PROD_W     = SAMPLE_W + COEFF_W;
    localparam int ACC_W      = 48;
    localparam int INDEX_W    = 8;
    localparam int WIN_LEN_W  = 9;
    localparam int BIN_STEP_W = 8;
    localparam int POWER_W    = 63;
    localparam int SQ_IN_W    = 32;
    localparam int SQ_W       = 2 * SQ_IN_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    localparam logic [WIN_LEN_W-1:0]  WIN_LEN_RESET  = 9'd256;
    localparam logic [BIN_STEP_W-1:0] BIN_STEP_RESET = 8'd0;

    localparam logic [ACC_W-1:0]   SQUARE_LIMIT = 48'd3037000499;
    localparam logic [POWER_W-1:0] POWER_MAX    = {POWER_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_STEP      = 1'b1;

    localparam logic OP_WRITE_COEFF = 1'b0;
    localparam logic OP_SAMPLE      = 1'b1;

    typedef struct packed {
        logic valid;
        logic last;
    } t_pipe_ctl;

endpackage

// ----- design/single_bin_dft_power.sv -----
// Single-bin DFT power: one input word per cycle when not stalled, table writes and
// samples alike. A window-closing sample passes input register, multiply, accumulate,
// scale and magnitude, clamp, square and saturating sum stages to give its result.
// Coefficient reads come from a registered memory port addressed by the next phase.
// The whole pipeline holds while the output word is stalled.
// Synchronous active-low reset clears control, phase, count, accumulators and
// configuration; the coefficient tables keep their contents.
module single_bin_dft_power #(
    parameter int TABLE_DEPTH   = sbdp_pkg::TABLE_DEPTH_DEF,
    parameter int FRACTION_BITS = sbdp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_operation,
    input  logic [sbdp_pkg::INDEX_W-1:0]          i_coeff_index,
    input  logic signed [sbdp_pkg::COEFF_W-1:0]   i_cos_coeff,
    input  logic signed [sbdp_pkg::COEFF_W-1:0]   i_sin_coeff,
    input  logic signed [sbdp_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [sbdp_pkg::POWER_W-1:0]          o_bin_power,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sbdp_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [sbdp_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int PH_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [sbdp_pkg::WIN_LEN_W-1:0]      r_win_len;
    logic [sbdp_pkg::BIN_STEP_W-1:0]     r_bin_step;
    logic                                advance;
    logic                                accept;
    logic                                sample_take;
    logic                                coeff_write;
    logic [PH_W-1:0]                     rd_addr;
    logic                                last;
    logic signed [sbdp_pkg::COEFF_W-1:0] rd_cos;
    logic signed [sbdp_pkg::COEFF_W-1:0] rd_sin;
    sbdp_pkg::t_pipe_ctl                 in_ctl;
    logic                                acc_valid;
    logic signed [sbdp_pkg::ACC_W-1:0]   acc_re;
    logic signed [sbdp_pkg::ACC_W-1:0]   acc_im;

    assign advance     = !o_out_valid || !i_out_stall;
    assign o_in_stall  = !advance;
    assign accept      = i_in_valid && advance;
    assign sample_take = accept && (i_operation == sbdp_pkg::OP_SAMPLE);
    assign coeff_write = accept && (i_operation == sbdp_pkg::OP_WRITE_COEFF);
    assign o_cfg_ready = 1'b1;

    assign in_ctl = {sample_take, last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len  <= sbdp_pkg::WIN_LEN_RESET;
            r_bin_step <= sbdp_pkg::BIN_STEP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                sbdp_pkg::REG_WINDOW_LENGTH: begin
                    r_win_len <= i_cfg_data[sbdp_pkg::WIN_LEN_W-1:0];
                end
                sbdp_pkg::REG_BIN_STEP: begin
                    r_bin_step <= i_cfg_data[sbdp_pkg::BIN_STEP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    sbdp_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_sample_take (sample_take),
        .i_win_len     (r_win_len),
        .i_bin_step    (r_bin_step),
        .o_rd_addr     (rd_addr),
        .o_last        (last)
    );

    sbdp_coeff_mem #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mem (
        .i_clk      (i_clk),
        .i_wr_en    (coeff_write),
        .i_wr_index (i_coeff_index),
        .i_wr_cos   (i_cos_coeff),
        .i_wr_sin   (i_sin_coeff),
        .i_rd_addr  (rd_addr),
        .o_rd_cos   (rd_cos),
        .o_rd_sin   (rd_sin)
    );

    sbdp_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_ctl     (in_ctl),
        .i_sample  (i_sample),
        .i_cos     (rd_cos),
        .i_sin     (rd_sin),
        .o_valid   (acc_valid),
        .o_re      (acc_re),
        .o_im      (acc_im)
    );

    sbdp_power #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_power (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_valid   (acc_valid),
        .i_re      (acc_re),
        .i_im      (acc_im),
        .o_valid   (o_out_valid),
        .o_power   (o_bin_power)
    );

endmodule

// ----- design/sbdp_coeff_mem.sv -----
// Cosine/sine coefficient memory with a registered read port and write bypass.
// Depends on sbdp_pkg.
module sbdp_coeff_mem #(
    parameter int TABLE_DEPTH = sbdp_pkg::TABLE_DEPTH_DEF,
    localparam int PH_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_wr_en,
    input  logic [sbdp_pkg::INDEX_W-1:0]           i_wr_index,
    input  logic signed [sbdp_pkg::COEFF_W-1:0]    i_wr_cos,
    input  logic signed [sbdp_pkg::COEFF_W-1:0]    i_wr_sin,
    input  logic [PH_W-1:0]                        i_rd_addr,
    output logic signed [sbdp_pkg::COEFF_W-1:0]    o_rd_cos,
    output logic signed [sbdp_pkg::COEFF_W-1:0]    o_rd_sin
);

    localparam int IW = ((PH_W > sbdp_pkg::INDEX_W) ? PH_W : sbdp_pkg::INDEX_W) + 1;
    localparam int WORD_W = 2 * sbdp_pkg::COEFF_W;

    logic [WORD_W-1:0] r_mem [0:TABLE_DEPTH-1];
    logic [WORD_W-1:0] r_rd_word;
    logic [WORD_W-1:0] wr_word;
    logic [PH_W-1:0]   wr_addr;
    logic              wr_ok;

    assign wr_ok   = IW'(i_wr_index) < IW'(TABLE_DEPTH);
    assign wr_addr = PH_W'(i_wr_index);
    assign wr_word = {i_wr_cos, i_wr_sin};

    always_ff @(posedge i_clk) begin
        if (i_wr_en && wr_ok) begin
            r_mem[wr_addr] <= wr_word;
        end
        if (i_wr_en && wr_ok && (wr_addr == i_rd_addr)) begin
            r_rd_word <= wr_word;
        end else begin
            r_rd_word <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_cos = r_rd_word[WORD_W-1:sbdp_pkg::COEFF_W];
    assign o_rd_sin = r_rd_word[sbdp_pkg::COEFF_W-1:0];

endmodule

// ----- design/sbdp_seq.sv -----
// Phase index and sample count sequencer; yields next read address and window end.
// Depends on sbdp_pkg.
module sbdp_seq #(
    parameter int TABLE_DEPTH = sbdp_pkg::TABLE_DEPTH_DEF,
    localparam int PH_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_sample_take,
    input  logic [sbdp_pkg::WIN_LEN_W-1:0]       i_win_len,
    input  logic [sbdp_pkg::BIN_STEP_W-1:0]      i_bin_step,
    output logic [PH_W-1:0]                      o_rd_addr,
    output logic                                 o_last
);

    localparam int LEN_W = $clog2(TABLE_DEPTH + 1);
    localparam int W = ((LEN_W > sbdp_pkg::WIN_LEN_W) ? LEN_W : sbdp_pkg::WIN_LEN_W) + 1;

    logic [PH_W-1:0] r_phase;
    logic [PH_W-1:0] r_count;
    logic [PH_W-1:0] n_phase;
    logic [PH_W-1:0] n_count;
    logic [W-1:0]    len;
    logic [W-1:0]    wl_ext;
    logic [W-1:0]    step_sum;
    logic [W-1:0]    wrap1;
    logic [W-1:0]    wrap2;
    logic [W-1:0]    cnt_inc;

    assign wl_ext = W'(i_win_len);

    always_comb begin
        if (wl_ext == '0) begin
            len = W'(1);
        end else if (wl_ext > W'(TABLE_DEPTH)) begin
            len = W'(TABLE_DEPTH);
        end else begin
            len = wl_ext;
        end
    end

    assign step_sum = W'(r_phase) + W'(i_bin_step);
    assign wrap1    = (step_sum >= len) ? (step_sum - len) : step_sum;
    assign wrap2    = (wrap1 >= len) ? '0 : wrap1;
    assign cnt_inc  = W'(r_count) + W'(1);
    assign o_last   = cnt_inc >= len;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (!i_rst_n) begin
            n_phase = '0;
            n_count = '0;
        end else if (i_sample_take) begin
            if (o_last) begin
                n_phase = '0;
                n_count = '0;
            end else begin
                n_phase = PH_W'(wrap2);
                n_count = PH_W'(cnt_inc);
            end
        end
    end

    assign o_rd_addr = n_phase;

    always_ff @(posedge i_clk) begin
        r_phase <= n_phase;
        r_count <= n_count;
    end

endmodule

// ----- design/sbdp_mac.sv -----
// Input register, coefficient multiply and real/imaginary accumulate stages.
// Depends on sbdp_pkg.
module sbdp_mac (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_advance,
    input  sbdp_pkg::t_pipe_ctl                   i_ctl,
    input  logic signed [sbdp_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic signed [sbdp_pkg::COEFF_W-1:0]   i_cos,
    input  logic signed [sbdp_pkg::COEFF_W-1:0]   i_sin,
    output logic                                  o_valid,
    output logic signed [sbdp_pkg::ACC_W-1:0]     o_re,
    output logic signed [sbdp_pkg::ACC_W-1:0]     o_im
);

    sbdp_pkg::t_pipe_ctl                  r1_ctl;
    logic signed [sbdp_pkg::SAMPLE_W-1:0] r1_sample;
    logic signed [sbdp_pkg::COEFF_W-1:0]  r1_cos;
    logic signed [sbdp_pkg::COEFF_W-1:0]  r1_sin;

    sbdp_pkg::t_pipe_ctl                  r2_ctl;
    logic signed [sbdp_pkg::PROD_W-1:0]   r2_prod_re;
    logic signed [sbdp_pkg::PROD_W-1:0]   r2_prod_im;

    logic signed [sbdp_pkg::ACC_W-1:0]    r_acc_re;
    logic signed [sbdp_pkg::ACC_W-1:0]    r_acc_im;
    logic signed [sbdp_pkg::ACC_W-1:0]    sum_re;
    logic signed [sbdp_pkg::ACC_W-1:0]    sum_im;
    logic                                 r3_valid;
    logic signed [sbdp_pkg::ACC_W-1:0]    r3_re;
    logic signed [sbdp_pkg::ACC_W-1:0]    r3_im;

    assign sum_re = r_acc_re + sbdp_pkg::ACC_W'(r2_prod_re);
    assign sum_im = r_acc_im + sbdp_pkg::ACC_W'(r2_prod_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_ctl   <= '0;
            r2_ctl   <= '0;
            r3_valid <= 1'b0;
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (i_advance) begin
            r1_ctl   <= i_ctl;
            r2_ctl   <= r1_ctl;
            r3_valid <= r2_ctl.valid && r2_ctl.last;
            if (r2_ctl.valid) begin
                if (r2_ctl.last) begin
                    r_acc_re <= '0;
                    r_acc_im <= '0;
                end else begin
                    r_acc_re <= sum_re;
                    r_acc_im <= sum_im;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r1_sample  <= i_sample;
            r1_cos     <= i_cos;
            r1_sin     <= i_sin;
            r2_prod_re <= r1_cos * r1_sample;
            r2_prod_im <= r1_sin * r1_sample;
            r3_re      <= sum_re;
            r3_im      <= sum_im;
        end
    end

    assign o_valid = r3_valid;
    assign o_re    = r3_re;
    assign o_im    = r3_im;

endmodule

// ----- design/sbdp_power.sv -----
// Scale, magnitude, clamp, square and saturating sum stages with output register.
// Depends on sbdp_pkg.
module sbdp_power #(
    parameter int FRACTION_BITS = sbdp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_advance,
    input  logic                                i_valid,
    input  logic signed [sbdp_pkg::ACC_W-1:0]   i_re,
    input  logic signed [sbdp_pkg::ACC_W-1:0]   i_im,
    output logic                                o_valid,
    output logic [sbdp_pkg::POWER_W-1:0]        o_power
);

    logic signed [sbdp_pkg::ACC_W-1:0]  sh_re;
    logic signed [sbdp_pkg::ACC_W-1:0]  sh_im;
    logic                               r4_valid;
    logic [sbdp_pkg::ACC_W-1:0]         r4_mag_re;
    logic [sbdp_pkg::ACC_W-1:0]         r4_mag_im;
    logic                               r5_valid;
    logic                               r5_sat;
    logic [sbdp_pkg::SQ_IN_W-1:0]       r5_a;
    logic [sbdp_pkg::SQ_IN_W-1:0]       r5_b;
    logic                               r6_valid;
    logic                               r6_sat;
    logic [sbdp_pkg::SQ_W-1:0]          r6_sq_a;
    logic [sbdp_pkg::SQ_W-1:0]          r6_sq_b;
    logic [sbdp_pkg::SQ_W:0]            sq_sum;
    logic                               r_out_valid;
    logic [sbdp_pkg::POWER_W-1:0]       r_out_power;

    assign sh_re  = i_re >>> FRACTION_BITS;
    assign sh_im  = i_im >>> FRACTION_BITS;
    assign sq_sum = {1'b0, r6_sq_a} + {1'b0, r6_sq_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r6_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_advance) begin
            r4_valid    <= i_valid;
            r5_valid    <= r4_valid;
            r6_valid    <= r5_valid;
            r_out_valid <= r6_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r4_mag_re   <= sh_re[sbdp_pkg::ACC_W-1] ? sbdp_pkg::ACC_W'(-sh_re)
                                                    : sbdp_pkg::ACC_W'(sh_re);
            r4_mag_im   <= sh_im[sbdp_pkg::ACC_W-1] ? sbdp_pkg::ACC_W'(-sh_im)
                                                    : sbdp_pkg::ACC_W'(sh_im);
            r5_sat      <= (r4_mag_re > sbdp_pkg::SQUARE_LIMIT) ||
                           (r4_mag_im > sbdp_pkg::SQUARE_LIMIT);
            r5_a        <= r4_mag_re[sbdp_pkg::SQ_IN_W-1:0];
            r5_b        <= r4_mag_im[sbdp_pkg::SQ_IN_W-1:0];
            r6_sat      <= r5_sat;
            r6_sq_a     <= r5_a * r5_a;
            r6_sq_b     <= r5_b * r5_b;
            if (r6_sat || (sq_sum[sbdp_pkg::SQ_W:sbdp_pkg::POWER_W] != '0)) begin
                r_out_power <= sbdp_pkg::POWER_MAX;
            end else begin
                r_out_power <= sq_sum[sbdp_pkg::POWER_W-1:0];
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_power = r_out_power;

endmodule

// ----- tb/sbdp_power_checker.sv -----
`timescale 1ns / 100ps
// Checker for single_bin_dft_power: watches the sample, result and register channels,
// predicts every bin_power word and compares it with what the block delivers.
// Depends on sbdp_pkg for field widths, opcodes and register indexes.
module sbdp_power_checker
    import sbdp_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic                       i_operation,
    input  logic [INDEX_W-1:0]         i_coeff_index,
    input  logic signed [COEFF_W-1:0]  i_cos_coeff,
    input  logic signed [COEFF_W-1:0]  i_sin_coeff,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic [POWER_W-1:0]         i_bin_power,
    input  logic                       i_cfg_valid,
    input  logic                       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    output int                         o_pending,
    output int                         o_mismatches
);

    logic signed [COEFF_W-1:0] cos_rom [TABLE_DEPTH_DEF];
    logic signed [COEFF_W-1:0] sin_rom [TABLE_DEPTH_DEF];
    longint                    re_acc;
    longint                    im_acc;
    int unsigned               rom_phase;
    int unsigned               sample_cnt;
    int unsigned               win_len;
    int unsigned               bin_step;
    logic [POWER_W-1:0]        expected_power [$];
    int                        mismatches = 0;

    function automatic logic [POWER_W-1:0] power_of(longint re, longint im);
        longint unsigned a;
        longint unsigned b;
        longint unsigned s;
        a = (re < 0) ? -re : re;
        b = (im < 0) ? -im : im;
        if (a > SQUARE_LIMIT || b > SQUARE_LIMIT)
            return POWER_MAX;
        s = a * a + b * b;
        if (s > POWER_MAX)
            return POWER_MAX;
        return s[POWER_W-1:0];
    endfunction

    task automatic absorb_sample(logic signed [SAMPLE_W-1:0] x);
        int unsigned len;
        int unsigned nxt;
        if (win_len == 0)
            len = 1;
        else if (win_len > TABLE_DEPTH_DEF)
            len = TABLE_DEPTH_DEF;
        else
            len = win_len;
        re_acc += longint'(cos_rom[rom_phase]) * longint'(x);
        im_acc += longint'(sin_rom[rom_phase]) * longint'(x);
        nxt = rom_phase + bin_step;
        if (nxt >= len)
            nxt -= len;
        if (nxt >= len)
            nxt = 0;
        rom_phase = nxt;
        sample_cnt++;
        if (sample_cnt >= len) begin
            expected_power.push_back(power_of(re_acc >>> FRACTION_BITS_DEF,
                                              im_acc >>> FRACTION_BITS_DEF));
            re_acc     = 0;
            im_acc     = 0;
            rom_phase  = 0;
            sample_cnt = 0;
        end
    endtask

    task automatic compare_power();
        logic [POWER_W-1:0] want;
        if (expected_power.size() == 0) begin
            if (mismatches < 10)
                $display("bin_power word with nothing expected: got %0d", i_bin_power);
            mismatches++;
        end else begin
            want = expected_power.pop_front();
            if (i_bin_power !== want) begin
                if (mismatches < 10)
                    $display("bin_power mismatch: expected %0d got %0d", want, i_bin_power);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            re_acc     = 0;
            im_acc     = 0;
            rom_phase  = 0;
            sample_cnt = 0;
            win_len    = WIN_LEN_RESET;
            bin_step   = BIN_STEP_RESET;
            expected_power.delete();
        end else begin
            if (i_out_valid && !i_out_stall)
                compare_power();
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_WINDOW_LENGTH)
                    win_len = i_cfg_data[WIN_LEN_W-1:0];
                else if (i_cfg_index == REG_BIN_STEP)
                    bin_step = i_cfg_data[BIN_STEP_W-1:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_operation == OP_WRITE_COEFF) begin
                    cos_rom[i_coeff_index] = i_cos_coeff;
                    sin_rom[i_coeff_index] = i_sin_coeff;
                end else begin
                    absorb_sample(i_sample);
                end
            end
        end
        o_pending    <= expected_power.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Top of the single_bin_dft_power testbench: clock, reset, stimulus and verdict.
// Instantiates the block and sbdp_power_checker; depends on sbdp_pkg.
module tb;
    import sbdp_pkg::*;

    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 12;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       in_valid  = 1'b0;
    logic                       in_stall;
    logic                       op        = OP_SAMPLE;
    logic [INDEX_W-1:0]         coeff_idx = '0;
    logic signed [COEFF_W-1:0]  cos_c     = '0;
    logic signed [COEFF_W-1:0]  sin_c     = '0;
    logic signed [SAMPLE_W-1:0] sample    = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [POWER_W-1:0]         bin_power;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data  = '0;

    int pending;
    int mismatches;
    int cycles        = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_requests = 0;
    int hold_granted  = 0;
    int hold_left     = 0;

    int unsigned phase_len  [PHASES] = '{256, 2, 7, 16, 5, 256, 1, 12, 0, 300, 33, 9};
    int unsigned phase_step [PHASES] = '{0, 1, 3, 15, 9, 255, 0, 200, 0, 37, 32, 4};

    always #4 clk = ~clk;

    single_bin_dft_power u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_operation   (op),
        .i_coeff_index (coeff_idx),
        .i_cos_coeff   (cos_c),
        .i_sin_coeff   (sin_c),
        .i_sample      (sample),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_bin_power   (bin_power),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    sbdp_power_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_operation   (op),
        .i_coeff_index (coeff_idx),
        .i_cos_coeff   (cos_c),
        .i_sin_coeff   (sin_c),
        .i_sample      (sample),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_bin_power   (bin_power),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_pending     (pending),
        .o_mismatches  (mismatches)
    );

    // hold off the result channel for a long stretch on request
    always @(posedge clk) begin
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_granted != hold_requests) begin
            out_stall    <= 1'b1;
            hold_left    <= HOLD_CYCLES;
            hold_granted <= hold_granted + 1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic signed [SAMPLE_W-1:0] pick_value();
        case ($urandom_range(11))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic send_word(logic o, logic [INDEX_W-1:0] idx, logic signed [COEFF_W-1:0] c,
                             logic signed [COEFF_W-1:0] s, logic signed [SAMPLE_W-1:0] x);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= o;
        coeff_idx <= idx;
        cos_c     <= c;
        sin_c     <= s;
        sample    <= x;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic feed(logic signed [SAMPLE_W-1:0] x);
        send_word(OP_SAMPLE, INDEX_W'($urandom), COEFF_W'($urandom), COEFF_W'($urandom), x);
    endtask

    task automatic load(logic [INDEX_W-1:0] idx, logic signed [COEFF_W-1:0] c,
                        logic signed [COEFF_W-1:0] s);
        send_word(OP_WRITE_COEFF, idx, c, s, SAMPLE_W'($urandom));
    endtask

    // drop valid and wait until every expected word is out, then let the pipe drain
    task automatic quiesce(int extra);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic configure(int unsigned len, int unsigned bstep);
        cfg_valid <= 1'b1;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_index <= REG_BIN_STEP;
        cfg_data  <= CFG_DATA_W'(bstep);
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        int p;
        int k;
        int n;
        int r;
        int unsigned eff;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // load both tables completely before any sample reads them
        load('0, 16'sh7FFF, 16'sh8000);
        for (k = 1; k < TABLE_DEPTH_DEF; k++)
            load(INDEX_W'(k), pick_value(), pick_value());
        quiesce(SETTLE_CYCLES);

        configure(1, 0);
        feed(16'sh7FFF);
        feed(16'sh8000);
        feed(16'sh0000);
        feed(16'shFFFF);
        load('0, 16'sh8000, 16'sh8000);
        feed(16'sh8000);
        load(8'hFF, 16'sh7FFF, 16'shFFFF);
        quiesce(SETTLE_CYCLES);
        configure(0, 0);
        feed(pick_value());
        feed(pick_value());
        quiesce(SETTLE_CYCLES);
        configure(3, 5);
        repeat (6) feed(pick_value());
        quiesce(SETTLE_CYCLES);
        configure(4, 200);
        repeat (4) feed(pick_value());
        quiesce(SETTLE_CYCLES);
        configure(5, 1);
        repeat (3) feed(pick_value());
        quiesce(SETTLE_CYCLES);
        configure(2, 1);
        repeat (3) feed(pick_value());

        for (p = 0; p < PHASES; p++) begin
            quiesce(SETTLE_CYCLES);
            configure(phase_len[p], phase_step[p]);
            case (p % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 65;
                    stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct <= 65;
                end
                default: begin
                    send_idle_pct = 13;
                    stall_pct <= 13;
                end
            endcase
            if (p == 1) begin
                send_idle_pct = 0;
                hold_requests <= hold_requests + 1;
            end
            if (phase_len[p] == 0)
                eff = 1;
            else if (phase_len[p] > TABLE_DEPTH_DEF)
                eff = TABLE_DEPTH_DEF;
            else
                eff = phase_len[p];
            n = (eff >= 64) ? eff + eff / 4 : 60;
            for (k = 0; k < n; k++) begin
                if (k == n / 2)
                    quiesce(0);
                r = $urandom_range(99);
                if (r < 85)
                    feed(pick_value());
                else if (r < 90)
                    load('0, pick_value(), pick_value());
                else if (r < 95)
                    load(INDEX_W'($urandom_range(eff - 1)), pick_value(), pick_value());
                else
                    load(INDEX_W'($urandom), pick_value(), pick_value());
            end
        end

        quiesce(SETTLE_CYCLES);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sbdp_pkg.sv
design/sbdp_coeff_mem.sv
design/sbdp_seq.sv
design/sbdp_mac.sv
design/sbdp_power.sv
design/single_bin_dft_power.sv
tb/sbdp_power_checker.sv
tb/tb.sv
